[hw/rtl/orl_pkg.sv]
// Shared types and codes for the ordered record list.
`timescale 1ns / 1ps
`default_nettype none
package orl_pkg;

  localparam int unsigned NWORDS = 5;
  localparam int unsigned WORD_W = 32;

  typedef logic [NWORDS-1:0][WORD_W-1:0] rec_t;

  // operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_COUNT,
    SLOT_POS,
    SLOT_IDX
  } slot_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;       // capture the input transaction
    logic      wr_append;  // write latched record at the tail
    logic      wr_move;    // write read data at idx (compaction)
    logic      rd_req;     // registered memory read
    logic      rd_next;    // read address is idx+1 instead of idx
    logic      idx_pos;    // idx <= position
    logic      idx_clr;
    logic      idx_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      emit;
    logic [1:0] status;
    slot_sel_t slot_sel;
    logic      words_rd;   // result words from read data
    logic      last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       pos_ok;
    logic       more;      // idx+1 < count
    logic       at_end;    // idx+1 == count
    logic       out_pending;
  } stat_t;

endpackage
`default_nettype wire

[hw/rtl/orl_ctrl.sv]
// Sequencing state machine for the ordered record list.
`timescale 1ns / 1ps
`default_nettype none
module orl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire orl_pkg::stat_t stat,
  output orl_pkg::cmd_t      cmd
);

  orl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= orl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.slot_sel = orl_pkg::SLOT_ZERO;
    cmd.status   = orl_pkg::ST_OK;
    busy         = (state_r != orl_pkg::S_IDLE) || stat.out_pending;
    case (state_r)
      orl_pkg::S_IDLE: begin
        if (start && !busy) begin
          cmd.load  = 1'b1;
          state_nxt = orl_pkg::S_DECIDE;
        end
      end
      orl_pkg::S_DECIDE: begin
        state_nxt = orl_pkg::S_IDLE;
        case (stat.op)
          orl_pkg::OP_APPEND: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            if (stat.full) begin
              cmd.status = orl_pkg::ST_FULL;
            end else begin
              cmd.wr_append = 1'b1;
              cmd.cnt_inc   = 1'b1;
              cmd.slot_sel  = orl_pkg::SLOT_COUNT;
            end
          end
          orl_pkg::OP_DELETE: begin
            if (stat.pos_ok) begin
              cmd.idx_pos = 1'b1;
              state_nxt   = orl_pkg::S_DEL_RD;
            end else begin
              cmd.emit     = 1'b1;
              cmd.last     = 1'b1;
              cmd.status   = orl_pkg::ST_INVALID;
              cmd.slot_sel = orl_pkg::SLOT_POS;
            end
          end
          orl_pkg::OP_DUMP: begin
            if (stat.empty) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.status = orl_pkg::ST_EMPTY;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = orl_pkg::S_DUMP_RD;
            end
          end
          default: begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.status = orl_pkg::ST_INVALID;
          end
        endcase
      end
      orl_pkg::S_DEL_RD: begin
        if (stat.more) begin
          cmd.rd_req  = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = orl_pkg::S_DEL_WR;
        end else begin
          cmd.cnt_dec  = 1'b1;
          cmd.emit     = 1'b1;
          cmd.last     = 1'b1;
          cmd.slot_sel = orl_pkg::SLOT_POS;
          state_nxt    = orl_pkg::S_IDLE;
        end
      end
      orl_pkg::S_DEL_WR: begin
        cmd.wr_move = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = orl_pkg::S_DEL_RD;
      end
      orl_pkg::S_DUMP_RD: begin
        cmd.rd_req = 1'b1;
        state_nxt  = orl_pkg::S_DUMP_EMIT;
      end
      orl_pkg::S_DUMP_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.words_rd = 1'b1;
        cmd.slot_sel = orl_pkg::SLOT_IDX;
        cmd.idx_inc  = 1'b1;
        if (stat.at_end) begin
          cmd.last  = 1'b1;
          state_nxt = orl_pkg::S_IDLE;
        end else begin
          state_nxt = orl_pkg::S_DUMP_RD;
        end
      end
      default: begin
        state_nxt = orl_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/orl_dp.sv]
// Record memory, count, index and result registers of the ordered record list.
`timescale 1ns / 1ps
`default_nettype none
module orl_dp #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire orl_pkg::cmd_t       cmd,
  output orl_pkg::stat_t           stat,
  input  wire logic [1:0]          in_op,
  input  wire logic [5:0]          in_position,
  input  wire orl_pkg::rec_t       in_rec,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [5:0]               out_slot,
  output orl_pkg::rec_t            out_rec,
  output logic [6:0]               out_count,
  output logic                     out_last
);

  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  orl_pkg::rec_t mem [MAX_RECORDS];

  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW:0]     idx_p1;
  logic [1:0]      op_r;
  logic [5:0]      pos_r;
  orl_pkg::rec_t   rec_r;
  orl_pkg::rec_t   rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [5:0]      out_slot_r, slot_nxt;
  orl_pkg::rec_t   out_rec_r;
  logic [6:0]      out_count_r;
  logic            out_last_r;

  assign idx_p1 = {1'b0, idx_r} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + {{(CW-1){1'b0}}, 1'b1};
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - {{(CW-1){1'b0}}, 1'b1};
    end
    idx_nxt = idx_r;
    if (cmd.idx_pos) begin
      idx_nxt = CW'(pos_r);
    end else if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_p1[CW-1:0];
    end
    case (cmd.slot_sel)
      orl_pkg::SLOT_COUNT: slot_nxt = 6'(count_r);
      orl_pkg::SLOT_POS:   slot_nxt = pos_r;
      orl_pkg::SLOT_IDX:   slot_nxt = 6'(idx_r);
      default:             slot_nxt = '0;
    endcase
  end

  assign rd_addr = cmd.rd_next ? idx_p1[AW-1:0] : idx_r[AW-1:0];
  assign wr_addr = cmd.wr_append ? count_r[AW-1:0] : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_append) begin
      mem[wr_addr] <= rec_r;
    end else if (cmd.wr_move) begin
      mem[wr_addr] <= rd_data_r;
    end
    if (cmd.rd_req) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      pos_r <= in_position;
      rec_r <= in_rec;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_slot_r   <= slot_nxt;
      out_rec_r    <= cmd.words_rd ? rd_data_r : '0;
      out_count_r  <= 7'(count_nxt);
      out_last_r   <= cmd.last;
    end
  end

  always_comb begin
    stat.op          = op_r;
    stat.full        = (count_r == CW'(MAX_RECORDS));
    stat.empty       = (count_r == '0);
    stat.pos_ok      = ({1'b0, pos_r} < 7'(count_r));
    stat.more        = (idx_p1 < {1'b0, count_r});
    stat.at_end      = (idx_p1 == {1'b0, count_r});
    stat.out_pending = out_valid_r;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_rec    = out_rec_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

[hw/rtl/ordered_record_list.sv]
// Top level of the ordered record list: controller plus datapath.
//
// Ordered list of up to MAX_RECORDS records of five signed 32-bit words,
// held in a single-port-write, registered-read memory. A transaction is
// taken when start is high and busy is low; busy stays high until the last
// result of that transaction has been shown on the out_ ports. Each result is
// marked by out_valid for exactly one cycle and cannot be stalled, so the
// receiver must capture it on that cycle; out_last flags the final one.
// Steps, set by the one memory read port and its output register:
//   append, bad delete, unknown op, empty dump: a single result; the next
//     transaction is accepted once that result has been shown.
//   delete at position p with n records: n - 1 - p records moved in
//     compaction (one read then one write per moved record), then the result.
//   dump of n records: n results; each record is read, then presented,
//     before the next record is read.
// Memory contents are not cleared at reset; only entries below the record
// count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module ordered_record_list #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_op,
  input  wire logic [5:0]         in_position,
  input  wire logic signed [31:0] in_word_0,
  input  wire logic signed [31:0] in_word_1,
  input  wire logic signed [31:0] in_word_2,
  input  wire logic signed [31:0] in_word_3,
  input  wire logic signed [31:0] in_word_4,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [5:0]              out_slot,
  output logic signed [31:0]      out_word_0,
  output logic signed [31:0]      out_word_1,
  output logic signed [31:0]      out_word_2,
  output logic signed [31:0]      out_word_3,
  output logic signed [31:0]      out_word_4,
  output logic [6:0]              out_count,
  output logic                    out_last
);

  orl_pkg::cmd_t  cmd;
  orl_pkg::stat_t stat;
  orl_pkg::rec_t  in_rec;
  orl_pkg::rec_t  out_rec;

  // record word k lives in lane k
  assign in_rec[0] = in_word_0;
  assign in_rec[1] = in_word_1;
  assign in_rec[2] = in_word_2;
  assign in_rec[3] = in_word_3;
  assign in_rec[4] = in_word_4;

  assign out_word_0 = $signed(out_rec[0]);
  assign out_word_1 = $signed(out_rec[1]);
  assign out_word_2 = $signed(out_rec[2]);
  assign out_word_3 = $signed(out_rec[3]);
  assign out_word_4 = $signed(out_rec[4]);

  // sequencer: decodes the transaction, walks compaction and dump
  orl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // memory, count/index registers and the result register
  orl_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_op),
    .in_position (in_position),
    .in_rec      (in_rec),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_slot    (out_slot),
    .out_rec     (out_rec),
    .out_count   (out_count),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire

[hw/rtl/orl_checker.sv]
// Port-level assertions for the ordered record list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module orl_port_props #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [1:0] out_status,
  input wire logic [6:0] out_count,
  input wire logic       out_last
);

  // a result only belongs to a transaction still in flight
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while not busy");

  // an accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accepted transaction");

  // the final result closes the transaction; nothing follows right after
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result right after last");

  // only a dump gives more than one result, and each of those is ok
  a_multi_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == orl_pkg::ST_OK))
    else $error("non-final result with error status");

  // record count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= 7'(MAX_RECORDS)))
    else $error("count above capacity");

endmodule

bind ordered_record_list orl_port_props #(
  .MAX_RECORDS (MAX_RECORDS)
) u_orl_port_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_count  (out_count),
  .out_last   (out_last)
);
`default_nettype wire
